/* rtl/iaa_pkg.sv */
package iaa_pkg;

   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int QUOT_BITS  = VALUE_BITS + FRAC_BITS;
   localparam int WIDE_BITS  = QUOT_BITS + 1;

   localparam logic signed [VALUE_BITS-1:0] FIX_ONE  = 32'sd65536;
   localparam logic signed [WIDE_BITS-1:0]  WIDE_MAX = 49'sd2147483647;
   localparam logic signed [WIDE_BITS-1:0]  WIDE_MIN = -49'sd2147483648;

   typedef enum logic [4:0] {
      OP_LOAD    = 5'd0,
      OP_NEG     = 5'd1,
      OP_INV     = 5'd2,
      OP_MSTORE  = 5'd3,
      OP_MRECALL = 5'd4,
      OP_MCLEAR  = 5'd5,
      OP_MADD    = 5'd6,
      OP_MSUB    = 5'd7,
      OP_SADD    = 5'd8,
      OP_SSUB    = 5'd9,
      OP_SMUL    = 5'd10,
      OP_SDIV    = 5'd11,
      OP_SDIVBY  = 5'd12,
      OP_IADD    = 5'd13,
      OP_ISUB    = 5'd14,
      OP_IMUL    = 5'd15,
      OP_IDIV    = 5'd16,
      OP_ISECT   = 5'd17,
      OP_CLEAR   = 5'd18
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOVAL   = 2'd1,
      ST_BADOPND = 2'd2,
      ST_DIVZERO = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BS_EXEC,
      BS_MUL,
      BS_MULW,
      BS_DIVS,
      BS_DIVW,
      BS_FINISH
   } bstate_type;

   typedef struct packed {
      logic [4:0]                    req_type;
      logic signed [VALUE_BITS-1:0]  operand_lo;
      logic signed [VALUE_BITS-1:0]  operand_hi;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                    status;
      logic                          shown;
      logic signed [VALUE_BITS-1:0]  result_lo;
      logic signed [VALUE_BITS-1:0]  result_hi;
      logic                          saturated;
   } rsp_item_type;

   typedef struct packed {
      op_type                        op;
      logic signed [VALUE_BITS-1:0]  a;
      logic signed [VALUE_BITS-1:0]  b;
      logic                          bad;
   } cmd_type;

   // clamp a wide value to Q16.16, top bit flags saturation
   function automatic logic [VALUE_BITS:0] clamp_f(input logic signed [WIDE_BITS-1:0] v);
      logic [VALUE_BITS:0] r;
      if (v > WIDE_MAX) begin
         r = {1'b1, WIDE_MAX[VALUE_BITS-1:0]};
      end else if (v < WIDE_MIN) begin
         r = {1'b1, WIDE_MIN[VALUE_BITS-1:0]};
      end else begin
         r = {1'b0, v[VALUE_BITS-1:0]};
      end
      return r;
   endfunction

endpackage

/* rtl/iaa_front.sv */
module iaa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  iaa_pkg::req_item_type req_data,
   output logic                  full,
   output logic                  cmd_valid,
   output iaa_pkg::cmd_type      cmd,
   input  logic                  cmd_pop
);
   import iaa_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    entry;
   logic       do_push, do_pop;

   // classify the incoming transaction
   always_comb begin
      entry.op  = op_type'(req_data.req_type);
      entry.a   = req_data.operand_lo;
      entry.b   = req_data.operand_hi;
      entry.bad = req_data.operand_lo > req_data.operand_hi;
   end

   assign full      = cnt_ff[1];
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // advance pointers
   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_ptr: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> rd_ff != $past(rd_ff)) else $error("read pointer stuck");
   a_full_nopush: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> full) else $error("full dropped without pop");
`endif

endmodule

/* rtl/iaa_div.sv */
module iaa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [iaa_pkg::QUOT_BITS-1:0]  dividend,
   input  logic [iaa_pkg::VALUE_BITS-1:0] divisor,
   output logic                           done,
   output logic [iaa_pkg::QUOT_BITS-1:0]  quot
);
   import iaa_pkg::*;

   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in, d_ff, d_in;
   logic [QUOT_BITS-1:0]  quo_ff, quo_in;
   logic [VALUE_BITS:0]   rem_sh, diff;
   logic                  ge;

   // one restoring step per cycle
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[QUOT_BITS-1]};
      diff    = rem_sh - {1'b0, d_ff};
      ge      = rem_sh >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(QUOT_BITS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
         quo_in = {quo_ff[QUOT_BITS-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff) else $error("done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("start did not begin division");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("start while busy");
`endif

endmodule

/* rtl/iaa_back.sv */
module iaa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  iaa_pkg::cmd_type      cmd,
   output logic                  cmd_pop,
   output logic                  empty,
   input  logic                  pop,
   output iaa_pkg::rsp_item_type rsp_data
);
   import iaa_pkg::*;

   bstate_type                   state_ff, state_in;
   logic signed [VALUE_BITS-1:0] cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   logic signed [VALUE_BITS-1:0] mem_lo_ff, mem_lo_in, mem_hi_ff, mem_hi_in;
   logic                         cur_v_ff, cur_v_in, mem_v_ff, mem_v_in;
   op_type                       op_ff;
   logic signed [VALUE_BITS-1:0] a_ff, b_ff;
   logic [1:0]                   k_ff, k_in;
   logic                         sat_ff, sat_in;
   logic signed [VALUE_BITS-1:0] t_ff [4];
   logic signed [63:0]           p_ff;
   logic                         neg_ff;
   rsp_item_type                 rsp_ff, rsp_in;
   logic                         rsp_v_ff, rsp_v_in;

   logic                         out_free, latch_op, t_we, mul_we, div_start, div_done;
   logic signed [VALUE_BITS-1:0] t_val, sx, sy;
   logic [VALUE_BITS-1:0]        ax, ay;
   logic [QUOT_BITS-1:0]         quot;
   logic signed [63:0]           p_adj, p_sh;
   logic signed [WIDE_BITS-1:0]  q_wide;
   logic [VALUE_BITS:0]          c0, c1, cm, cd;
   logic                         four, last;
   logic signed [VALUE_BITS-1:0] u2, u3, mn01, mn23, mx01, mx23;
   status_type                   st;
   logic                         hide, go, emit, shown;

   assign out_free = !rsp_v_ff || pop;
   assign empty    = !rsp_v_ff;
   assign rsp_data = rsp_ff;

   // pick the operand pair for step k
   always_comb begin
      four = (op_ff == OP_IMUL) || (op_ff == OP_IDIV);
      last = four ? (k_ff == 2'd3) : (k_ff == 2'd1);
      case (op_ff)
         OP_SMUL, OP_SDIV: begin
            sx = k_ff[0] ? cur_hi_ff : cur_lo_ff;
            sy = a_ff;
         end
         OP_IMUL, OP_IDIV: begin
            sx = k_ff[1] ? cur_hi_ff : cur_lo_ff;
            sy = k_ff[0] ? b_ff : a_ff;
         end
         OP_SDIVBY: begin
            sx = a_ff;
            sy = k_ff[0] ? cur_hi_ff : cur_lo_ff;
         end
         default: begin
            sx = FIX_ONE;
            sy = k_ff[0] ? cur_lo_ff : cur_hi_ff;
         end
      endcase
      ax = sx[VALUE_BITS-1] ? VALUE_BITS'(-sx) : VALUE_BITS'(sx);
      ay = sy[VALUE_BITS-1] ? VALUE_BITS'(-sy) : VALUE_BITS'(sy);
   end

   iaa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({ax, {FRAC_BITS{1'b0}}}),
      .divisor  (ay),
      .done     (div_done),
      .quot     (quot)
   );

   // scale the product and the quotient back to Q16.16
   always_comb begin
      p_adj  = p_ff + (p_ff[63] ? 64'sd65535 : 64'sd0);
      p_sh   = p_adj >>> FRAC_BITS;
      cm     = clamp_f(p_sh[WIDE_BITS-1:0]);
      q_wide = neg_ff ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      cd     = clamp_f(q_wide);
   end

   // min and max over the step results
   always_comb begin
      u2   = four ? t_ff[2] : t_ff[0];
      u3   = four ? t_ff[3] : t_ff[1];
      mn01 = (t_ff[0] < t_ff[1]) ? t_ff[0] : t_ff[1];
      mn23 = (u2 < u3) ? u2 : u3;
      mx01 = (t_ff[0] > t_ff[1]) ? t_ff[0] : t_ff[1];
      mx23 = (u2 > u3) ? u2 : u3;
   end

   // decode and run the commands that finish in the execute state, sequence the multi-step ones
   always_comb begin
      state_in  = state_ff;
      cur_lo_in = cur_lo_ff;
      cur_hi_in = cur_hi_ff;
      cur_v_in  = cur_v_ff;
      mem_lo_in = mem_lo_ff;
      mem_hi_in = mem_hi_ff;
      mem_v_in  = mem_v_ff;
      k_in      = k_ff;
      sat_in    = sat_ff;
      rsp_in    = rsp_ff;
      rsp_v_in  = rsp_v_ff && !pop;
      cmd_pop   = 1'b0;
      latch_op  = 1'b0;
      t_we      = 1'b0;
      t_val     = cm[VALUE_BITS-1:0];
      mul_we    = 1'b0;
      div_start = 1'b0;
      st        = ST_OK;
      hide      = 1'b0;
      go        = 1'b0;
      emit      = 1'b1;
      shown     = 1'b0;
      c0        = '0;
      c1        = '0;
      case (state_ff)
         BS_EXEC: begin
            case (cmd.op)
               OP_LOAD: begin
                  if (cmd.bad) begin
                     st   = ST_BADOPND;
                     hide = 1'b1;
                  end else begin
                     cur_lo_in = cmd.a;
                     cur_hi_in = cmd.b;
                     cur_v_in  = 1'b1;
                  end
               end
               OP_NEG: begin
                  if (cur_v_ff) begin
                     c0 = clamp_f(-WIDE_BITS'(cur_hi_ff));
                     c1 = clamp_f(-WIDE_BITS'(cur_lo_ff));
                  end
               end
               OP_INV, OP_SDIVBY: begin
                  if (cur_v_ff) begin
                     if (cur_lo_ff <= 0 && cur_hi_ff >= 0) begin
                        st       = ST_DIVZERO;
                        cur_v_in = 1'b0;
                     end else begin
                        go = 1'b1;
                     end
                  end
               end
               OP_MSTORE: begin
                  if (cur_v_ff) begin
                     mem_lo_in = cur_lo_ff;
                     mem_hi_in = cur_hi_ff;
                     mem_v_in  = 1'b1;
                  end
               end
               OP_MRECALL: begin
                  if (mem_v_ff) begin
                     cur_lo_in = mem_lo_ff;
                     cur_hi_in = mem_hi_ff;
                     cur_v_in  = 1'b1;
                  end
               end
               OP_MCLEAR: begin
                  mem_lo_in = '0;
                  mem_hi_in = '0;
                  mem_v_in  = 1'b0;
               end
               OP_MADD: begin
                  if (mem_v_ff && cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(mem_lo_ff) + WIDE_BITS'(cur_lo_ff));
                     c1 = clamp_f(WIDE_BITS'(mem_hi_ff) + WIDE_BITS'(cur_hi_ff));
                  end
               end
               OP_MSUB: begin
                  if (mem_v_ff && cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(mem_lo_ff) - WIDE_BITS'(cur_hi_ff));
                     c1 = clamp_f(WIDE_BITS'(mem_hi_ff) - WIDE_BITS'(cur_lo_ff));
                  end
               end
               OP_SADD: begin
                  if (cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(cur_lo_ff) + WIDE_BITS'(cmd.a));
                     c1 = clamp_f(WIDE_BITS'(cur_hi_ff) + WIDE_BITS'(cmd.a));
                  end
               end
               OP_SSUB: begin
                  if (cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(cur_lo_ff) - WIDE_BITS'(cmd.a));
                     c1 = clamp_f(WIDE_BITS'(cur_hi_ff) - WIDE_BITS'(cmd.a));
                  end
               end
               OP_SMUL: begin
                  go = cur_v_ff;
               end
               OP_SDIV: begin
                  if (cur_v_ff) begin
                     if (cmd.a == 0) begin
                        st       = ST_DIVZERO;
                        cur_v_in = 1'b0;
                     end else begin
                        go = 1'b1;
                     end
                  end
               end
               OP_IADD: begin
                  if (cmd.bad) begin
                     st = ST_BADOPND;
                  end else if (cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(cur_lo_ff) + WIDE_BITS'(cmd.a));
                     c1 = clamp_f(WIDE_BITS'(cur_hi_ff) + WIDE_BITS'(cmd.b));
                  end
               end
               OP_ISUB: begin
                  if (cmd.bad) begin
                     st = ST_BADOPND;
                  end else if (cur_v_ff) begin
                     c0 = clamp_f(WIDE_BITS'(cur_lo_ff) - WIDE_BITS'(cmd.b));
                     c1 = clamp_f(WIDE_BITS'(cur_hi_ff) - WIDE_BITS'(cmd.a));
                  end
               end
               OP_IMUL: begin
                  if (cmd.bad) begin
                     st = ST_BADOPND;
                  end else begin
                     go = cur_v_ff;
                  end
               end
               OP_IDIV: begin
                  if (cmd.bad) begin
                     st = ST_BADOPND;
                  end else if (cmd.a <= 0 && cmd.b >= 0) begin
                     st       = ST_DIVZERO;
                     cur_v_in = 1'b0;
                  end else begin
                     go = cur_v_ff;
                  end
               end
               OP_ISECT: begin
                  if (cmd.bad) begin
                     st = ST_BADOPND;
                  end else if (cur_v_ff) begin
                     cur_lo_in = (cur_lo_ff > cmd.a) ? cur_lo_ff : cmd.a;
                     cur_hi_in = (cur_hi_ff < cmd.b) ? cur_hi_ff : cmd.b;
                     if (cur_lo_in > cur_hi_in) begin
                        cur_v_in  = 1'b0;
                        cur_lo_in = cur_lo_ff;
                        cur_hi_in = cur_hi_ff;
                     end
                  end
               end
               OP_CLEAR: begin
                  cur_v_in = 1'b0;
                  mem_v_in = 1'b0;
                  emit     = 1'b0;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            // apply clamped pairs
            case (cmd.op)
               OP_NEG, OP_SADD, OP_SSUB: begin
                  if (cur_v_ff) begin
                     cur_lo_in = c0[VALUE_BITS-1:0];
                     cur_hi_in = c1[VALUE_BITS-1:0];
                  end
               end
               OP_IADD, OP_ISUB: begin
                  if (cur_v_ff && !cmd.bad) begin
                     cur_lo_in = c0[VALUE_BITS-1:0];
                     cur_hi_in = c1[VALUE_BITS-1:0];
                  end
               end
               OP_MADD, OP_MSUB: begin
                  if (mem_v_ff && cur_v_ff) begin
                     mem_lo_in = c0[VALUE_BITS-1:0];
                     mem_hi_in = c1[VALUE_BITS-1:0];
                  end
               end
               default: begin
               end
            endcase
            if (st == ST_OK && !cur_v_in) begin
               st = ST_NOVAL;
            end
            shown = cur_v_in && !hide;
            if (!cmd_valid) begin
               // hold both intervals and their valid flags
               cur_lo_in = cur_lo_ff;
               cur_hi_in = cur_hi_ff;
               cur_v_in  = cur_v_ff;
               mem_lo_in = mem_lo_ff;
               mem_hi_in = mem_hi_ff;
               mem_v_in  = mem_v_ff;
            end else if (go) begin
               cur_lo_in = cur_lo_ff;
               cur_hi_in = cur_hi_ff;
               cur_v_in  = cur_v_ff;
               cmd_pop   = 1'b1;
               latch_op  = 1'b1;
               k_in      = 2'd0;
               sat_in    = 1'b0;
               state_in  = (cmd.op == OP_SMUL || cmd.op == OP_IMUL) ? BS_MUL : BS_DIVS;
            end else if (!emit || out_free) begin
               cmd_pop = 1'b1;
               if (emit) begin
                  rsp_v_in         = 1'b1;
                  rsp_in.status    = st;
                  rsp_in.shown     = shown;
                  rsp_in.result_lo = shown ? cur_lo_in : '0;
                  rsp_in.result_hi = shown ? cur_hi_in : '0;
                  rsp_in.saturated = c0[VALUE_BITS] || c1[VALUE_BITS];
               end
            end else begin
               cur_lo_in = cur_lo_ff;
               cur_hi_in = cur_hi_ff;
               cur_v_in  = cur_v_ff;
               mem_lo_in = mem_lo_ff;
               mem_hi_in = mem_hi_ff;
               mem_v_in  = mem_v_ff;
            end
         end
         BS_MUL: begin
            mul_we   = 1'b1;
            state_in = BS_MULW;
         end
         BS_MULW: begin
            t_we     = 1'b1;
            t_val    = cm[VALUE_BITS-1:0];
            sat_in   = sat_ff || cm[VALUE_BITS];
            k_in     = k_ff + 2'd1;
            state_in = last ? BS_FINISH : BS_MUL;
         end
         BS_DIVS: begin
            div_start = 1'b1;
            state_in  = BS_DIVW;
         end
         BS_DIVW: begin
            if (div_done) begin
               t_we     = 1'b1;
               t_val    = cd[VALUE_BITS-1:0];
               sat_in   = sat_ff || cd[VALUE_BITS];
               k_in     = k_ff + 2'd1;
               state_in = last ? BS_FINISH : BS_DIVS;
            end
         end
         BS_FINISH: begin
            if (out_free) begin
               cur_lo_in        = (mn01 < mn23) ? mn01 : mn23;
               cur_hi_in        = (mx01 > mx23) ? mx01 : mx23;
               rsp_v_in         = 1'b1;
               rsp_in.status    = ST_OK;
               rsp_in.shown     = 1'b1;
               rsp_in.result_lo = cur_lo_in;
               rsp_in.result_hi = cur_hi_in;
               rsp_in.saturated = sat_ff;
               state_in         = BS_EXEC;
            end
         end
         default: begin
            state_in = BS_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BS_EXEC;
         cur_lo_ff <= '0;
         cur_hi_ff <= '0;
         cur_v_ff  <= 1'b0;
         mem_lo_ff <= '0;
         mem_hi_ff <= '0;
         mem_v_ff  <= 1'b0;
         rsp_v_ff  <= 1'b0;
         k_ff      <= '0;
         sat_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cur_lo_ff <= cur_lo_in;
         cur_hi_ff <= cur_hi_in;
         cur_v_ff  <= cur_v_in;
         mem_lo_ff <= mem_lo_in;
         mem_hi_ff <= mem_hi_in;
         mem_v_ff  <= mem_v_in;
         rsp_v_ff  <= rsp_v_in;
         k_ff      <= k_in;
         sat_ff    <= sat_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (latch_op) begin
         op_ff <= cmd.op;
         a_ff  <= cmd.a;
         b_ff  <= cmd.b;
      end
      if (mul_we) begin
         p_ff <= sx * sy;
      end
      if (div_start) begin
         neg_ff <= sx[VALUE_BITS-1] ^ sy[VALUE_BITS-1];
      end
      if (t_we) begin
         t_ff[k_ff] <= t_val;
      end
   end

`ifndef ASSERT_OFF
   a_iter_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BS_EXEC) |-> cur_v_ff) else $error("iteration without interval");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !pop) |=> (rsp_v_ff && $stable(rsp_ff)))
      else $error("waiting result overwritten");
   a_start_state: assert property (@(posedge clock) disable iff (reset)
      div_start |-> state_ff == BS_DIVS) else $error("divider started out of sequence");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BS_EXEC) |-> !cmd_pop) else $error("command taken while busy");
`endif

endmodule

/* rtl/interval_arithmetic_accumulator_unit.sv */
// Channel   Ports                          Handshake
// command   push, full, req_data           taken when push && !full
// result    pop, empty, rsp_data           taken when pop && !empty
//
// Simple commands run in the decode state and finish once the result register is free.
// Multiply commands are decoded, then form 2 or 4 products (a multiply and a
// wait state each) and end in a finish state. Divide commands form 2 or 4
// quotients, each a divider start and a wait on the one-bit-per-cycle divider, then finish.
// Reset is synchronous and clears both intervals, the command queue and the result register.
// A two-entry command queue keeps taking commands while a result waits.
module interval_arithmetic_accumulator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  iaa_pkg::req_item_type req_data,
   output logic                  full,
   output logic                  empty,
   input  logic                  pop,
   output iaa_pkg::rsp_item_type rsp_data
);
   import iaa_pkg::*;

   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   iaa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   iaa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
